### hw/rtl/wcpm_pkg.sv
// Shared constants and types for the wildcard pattern matcher.
package wcpm_pkg;

	localparam int MAX_PATTERN_DEF = 32;

	localparam logic [7:0] STAR_BYTE  = 8'h2A;
	localparam logic [7:0] QMARK_BYTE = 8'h3F;

	// register index of pattern_length on the APB port
	localparam logic REG_PATTERN_LENGTH = 1'b0;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_TEXT = 2'd1,
		CMD_END  = 2'd2
	} wcpm_cmd_t;

	// broadcast to every cell
	typedef struct packed {
		logic       advance;
		logic       start;
		logic [7:0] byte_value;
	} wcpm_ctrl_t;

	// handed from cell j-1 to cell j
	typedef struct packed {
		logic init_m;
		logic old_m;
		logic new_m;
	} wcpm_link_t;

endpackage

### hw/rtl/wcpm_cell.sv
// One pattern position: holds its pattern byte and its match bit.
module wcpm_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wcpm_pkg::wcpm_ctrl_t ctrl,
	input  logic                load_en,
	input  wcpm_pkg::wcpm_link_t link_in,
	output wcpm_pkg::wcpm_link_t link_out
);
	import wcpm_pkg::*;

	logic [7:0] pat_q;
	logic       row_q;
	logic       is_star;
	logic       hit;
	logic       init_here;
	logic       old_here;
	logic       new_here;

	always_ff @(posedge clk) begin
		if (load_en) begin
			pat_q <= ctrl.byte_value;
		end
	end

	always_comb begin
		is_star   = (pat_q == STAR_BYTE);
		hit       = (pat_q == QMARK_BYTE) || (pat_q == ctrl.byte_value);
		// leading run of stars for the empty text
		init_here = link_in.init_m & is_star;
		old_here  = ctrl.start ? init_here : row_q;
		if (is_star) begin
			new_here = link_in.old_m | link_in.new_m | old_here;
		end else begin
			new_here = hit & link_in.old_m;
		end
		link_out.init_m = init_here;
		link_out.old_m  = old_here;
		link_out.new_m  = new_here;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 1'b0;
		end else if (ctrl.advance) begin
			row_q <= new_here;
		end
	end

endmodule

### hw/rtl/wildcard_pattern_matcher.sv
// Glob pattern matcher: a row of cells, one per pattern byte.
// A result word appears in the cycle after its text or end word is accepted.
// Takes one input word per cycle unless a held result stalls s_tready; the cycle
// time is set by the match-bit ripple chain running through all MAX_PATTERN cells.
// Reset clears the match row, the length register and the output valid flag, and arms the
// text start; pattern bytes are not cleared and read as undefined until written.
module wildcard_pattern_matcher #(
	parameter int MAX_PATTERN = wcpm_pkg::MAX_PATTERN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [4:0] pattern_index, [12:5] byte_value, [15:13] zero
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [0] matched, [7:1] zero
	output logic        m_tlast,  // final_result
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wcpm_pkg::*;

	localparam int IW = $clog2(MAX_PATTERN + 1);

	logic [5:0]  len_q;
	logic        start_q;
	logic        m_tvalid_q;
	logic        matched_q;
	logic        last_q;

	logic        s_fire;
	logic [1:0]  cmd;
	logic [4:0]  pattern_index;
	logic [7:0]  byte_value;
	int          used_int;
	logic [IW-1:0] used_idx;

	wcpm_ctrl_t  ctrl;
	wcpm_link_t  link [MAX_PATTERN+1];
	logic [MAX_PATTERN:0] old_row;
	logic [MAX_PATTERN:0] new_row;

	assign cmd           = s_tuser;
	assign pattern_index = s_tdata[4:0];
	assign byte_value    = s_tdata[12:5];

	assign s_tready = !m_tvalid_q || m_tready;
	assign s_fire   = s_tvalid && s_tready;

	// APB
	assign pready = 1'b1;
	always_comb begin
		if (paddr[2] == REG_PATTERN_LENGTH) begin
			prdata = {26'd0, len_q};
		end else begin
			prdata = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 6'd0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_PATTERN_LENGTH) begin
			len_q <= pwdata[5:0];
		end
	end

	assign ctrl.advance    = s_fire && (cmd == CMD_TEXT);
	assign ctrl.start      = start_q;
	assign ctrl.byte_value = byte_value;

	// position zero: empty prefix always matches the empty text, never after a byte
	assign link[0].init_m = 1'b1;
	assign link[0].old_m  = start_q;
	assign link[0].new_m  = 1'b0;

	genvar g;
	generate
		for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
			logic load_en;
			assign load_en = s_fire && (cmd == CMD_LOAD) && (int'(pattern_index) == g);
			wcpm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.load_en  (load_en),
				.link_in  (link[g]),
				.link_out (link[g+1])
			);
		end
		for (g = 0; g <= MAX_PATTERN; g++) begin : g_row
			assign old_row[g] = link[g].old_m;
			assign new_row[g] = link[g].new_m;
		end
	endgenerate

	always_comb begin
		used_int = (int'(len_q) > MAX_PATTERN) ? MAX_PATTERN : int'(len_q);
		used_idx = IW'(used_int);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (s_fire) begin
			case (cmd)
				CMD_LOAD: start_q <= 1'b1;
				CMD_TEXT: start_q <= 1'b0;
				CMD_END:  start_q <= 1'b1;
				default:  start_q <= start_q;
			endcase
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_fire && (cmd == CMD_TEXT || cmd == CMD_END)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire && cmd == CMD_TEXT) begin
			matched_q <= new_row[used_idx];
			last_q    <= 1'b0;
		end else if (s_fire && cmd == CMD_END) begin
			matched_q <= old_row[used_idx];
			last_q    <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, matched_q};
	assign m_tlast  = last_q;

`ifndef ASSERT_OFF
	a_text_clears_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_TEXT |=> !start_q)
		else $error("text word did not clear text start");

	a_load_sets_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_LOAD |=> start_q)
		else $error("pattern load did not restart the text");

	a_end_gives_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_END |=> m_tvalid && m_tlast)
		else $error("end of text gave no final result");

	a_text_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_TEXT |=> m_tvalid && !m_tlast)
		else $error("text byte result marked final");

	a_row_empty_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && cmd == CMD_TEXT && start_q |-> old_row[0])
		else $error("empty prefix lost at text start");
`endif

endmodule
